### hdl/skl_pkg.sv
`default_nettype none
package skl_pkg;

  // Number of key cells in the chain
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_REMOVED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                    cmp;      // capture compare flags against key
    logic                    ins;      // open a slot and write key
    logic                    rem;      // close the slot of the matching key
    logic signed [KEY_W-1:0] key;
  } ctrl_t;

endpackage
`default_nettype wire

### hdl/skl_cell.sv
`default_nettype none
module skl_cell
  import skl_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire ctrl_t                   ctrl_i,
  input  wire logic                    occ_i,
  input  wire logic                    ge_left_i,
  input  wire logic signed [KEY_W-1:0] key_left_i,
  input  wire logic signed [KEY_W-1:0] key_right_i,
  output logic                         ge_o,
  output logic                         hit_o,
  output logic signed [KEY_W-1:0]      key_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    ge_q, ge_d;
  logic                    eq_q, eq_d;
  logic                    ge_left_q, ge_left_d;

  // Compare phase: an empty cell counts as greater or equal
  always_comb begin
    ge_d      = ge_q;
    eq_d      = eq_q;
    ge_left_d = ge_left_q;
    if (ctrl_i.cmp) begin
      ge_d      = !occ_i || (key_q >= ctrl_i.key);
      eq_d      = occ_i && (key_q == ctrl_i.key);
      ge_left_d = ge_left_i;
    end
  end

  // Update phase: shift right on insert, shift left on remove
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins) begin
      if (ge_left_q) begin
        key_d = key_left_i;
      end else if (ge_q) begin
        key_d = ctrl_i.key;
      end
    end else if (ctrl_i.rem && ge_q) begin
      key_d = key_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    ge_q      <= ge_d;
    eq_q      <= eq_d;
    ge_left_q <= ge_left_d;
  end

  // This cell is the lower bound and holds the key
  assign hit_o = ge_q && !ge_left_q && eq_q;
  assign ge_o  = ge_d;
  assign key_o = key_q;

endmodule
`default_nettype wire

### hdl/sorted_key_list.sv
// sorted_key_list: ascending multiset of signed keys in a chain of cells.
// Accept moves the sequencer to S_EXEC, which loads the output register. No new
// item is taken before S_EXEC ends or while the output stalls; cells compare,
// then shift. The count update at the end of an item gates the next compare.
// Reset (rst_ni low, async): list empty, no result pending; keys not cleared.
`default_nettype none
module sorted_key_list
  import skl_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              command_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [2:0]                   status_o,
  output logic [4:0]                   entry_count_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [1:0]              cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic                    out_valid_q, out_valid_d;
  logic [2:0]              status_q, status_d;
  logic [4:0]              entry_q, entry_d;
  logic [CNT_W+4:0]        count_ext;

  logic                    accept;
  logic                    hit_any;
  logic                    full;
  logic                    empty;
  logic                    do_ins, do_rem;
  ctrl_t                   ctrl;

  logic [CAPACITY-1:0]     ge;
  logic [CAPACITY-1:0]     hit;
  logic [CAPACITY-1:0]     occ;
  logic signed [KEY_W-1:0] keys [CAPACITY];

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign hit_any    = |hit;

  // Command decode for the update phase
  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    status_d = status_q;
    unique case (cmd_q)
      CMD_INSERT: begin
        status_d = full ? ST_FULL : ST_INSERTED;
        do_ins   = !full;
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (hit_any) begin
          status_d = ST_REMOVED;
          do_rem   = 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      CMD_SEARCH, CMD_SPARE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = hit_any ? ST_FOUND : ST_NOT_FOUND;
        end
      end
      default: status_d = ST_NOT_FOUND;
    endcase
  end

  // Broadcast control
  always_comb begin
    ctrl.cmp = accept;
    ctrl.ins = (state_q == S_EXEC) && do_ins;
    ctrl.rem = (state_q == S_EXEC) && do_rem;
    ctrl.key = (state_q == S_EXEC) ? key_q : key_i;
  end

  // Sequencer, count and output register
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    entry_d     = entry_q;
    count_ext   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (do_ins) begin
          count_d = count_q + CNT_W'(1);
        end else if (do_rem) begin
          count_d = count_q - CNT_W'(1);
        end
        count_ext   = {5'b0, count_d};
        entry_d     = count_ext[4:0];
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= key_i;
    end
    if (state_q == S_EXEC) begin
      status_q <= status_d;
      entry_q  <= entry_d;
    end
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    ge_left;
    logic signed [KEY_W-1:0] key_left;
    logic signed [KEY_W-1:0] key_right;

    assign occ[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign ge_left  = 1'b0;
      assign key_left = key_q;
    end else begin : g_mid
      assign ge_left  = ge[i-1];
      assign key_left = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign key_right = keys[i];
    end else begin : g_inner
      assign key_right = keys[i+1];
    end

    skl_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .ge_left_i   (ge_left),
      .key_left_i  (key_left),
      .key_right_i (key_right),
      .ge_o        (ge[i]),
      .hit_o       (hit[i]),
      .key_o       (keys[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_q;

  // A result appears only at the end of an update phase
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result without update phase");

  // Count stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // An accepted item is followed by its update phase
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("no update phase after accept");

  // At most one cell claims the lower-bound match
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(hit))
    else $error("more than one matching cell");

endmodule
`default_nettype wire
